// ===== sv/multi_led_blink_controller_defines.svh =====
`ifndef MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH

// check a property outside reset
`define MLBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define MLBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/mlbc_pkg.sv =====
package mlbc_pkg;

    localparam logic [1:0]  FUNC_TICK      = 2'd0;
    localparam logic [1:0]  FUNC_SET       = 2'd1;
    localparam logic [1:0]  FUNC_BLINK     = 2'd2;
    localparam logic [31:0] IN32_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] BLINKS_ENDLESS = 32'hFFFF_FFFF;
    localparam logic [2:0]  LEVELS_RESET   = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  led_index;
        logic        turn_on;
        logic [31:0] blink_total;
        logic [31:0] on_ticks;
        logic [31:0] off_ticks;
        logic [31:0] start_delay;
    } t_in_word;

    typedef struct packed {
        logic [2:0] pin_levels;
        logic [2:0] blinking_mask;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_TICK,
        OP_SET,
        OP_BLINK
    } t_unit_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_CMD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic accept;
        logic tick_visit;
        logic cmd_visit;
        logic load_out;
    } t_seq_ctrl;

endpackage

// ===== sv/mlbc_led_unit.sv =====
module mlbc_led_unit #(
    parameter int TIME_BITS = 32
) (
    input  mlbc_pkg::t_unit_op       i_op,
    input  mlbc_pkg::t_in_word       i_word,
    input  logic                     i_lit,
    input  logic [TIME_BITS-1:0]     i_elapsed,
    input  logic [TIME_BITS-1:0]     i_alarm,
    input  logic [31:0]              i_blinks,
    input  logic [TIME_BITS-1:0]     i_on_dur,
    input  logic [TIME_BITS-1:0]     i_off_dur,
    output logic                     o_lit,
    output logic [TIME_BITS-1:0]     o_elapsed,
    output logic [TIME_BITS-1:0]     o_alarm,
    output logic [31:0]              o_blinks,
    output logic [TIME_BITS-1:0]     o_on_dur,
    output logic [TIME_BITS-1:0]     o_off_dur,
    output logic                     o_armed
);
    import mlbc_pkg::*;

    localparam logic [TIME_BITS-1:0] NEVER = {TIME_BITS{1'b1}};

    function automatic logic [TIME_BITS-1:0] to_time(input logic [31:0] v);
        logic [TIME_BITS+31:0] wide;
        wide = {{TIME_BITS{1'b0}}, v};
        if (v == IN32_ALL_ONES) begin
            to_time = NEVER;
        end else begin
            to_time = wide[TIME_BITS-1:0];
        end
    endfunction

    logic [TIME_BITS-1:0] elapsed_inc;
    logic                 fire;
    logic [31:0]          blinks_dec;

    always_comb begin
        elapsed_inc = (i_elapsed == NEVER) ? i_elapsed : i_elapsed + TIME_BITS'(1);
        fire        = (i_alarm != NEVER) && (elapsed_inc >= i_alarm);
        blinks_dec  = (i_blinks == BLINKS_ENDLESS) ? i_blinks : i_blinks - 32'd1;
    end

    always_comb begin
        o_lit     = i_lit;
        o_elapsed = i_elapsed;
        o_alarm   = i_alarm;
        o_blinks  = i_blinks;
        o_on_dur  = i_on_dur;
        o_off_dur = i_off_dur;
        unique case (i_op)
            OP_TICK: begin
                o_elapsed = elapsed_inc;
                if (fire && i_lit) begin
                    o_lit     = 1'b0;
                    o_elapsed = '0;
                    if (blinks_dec == 32'd0) begin
                        o_alarm   = NEVER;
                        o_blinks  = BLINKS_ENDLESS;
                        o_on_dur  = '0;
                        o_off_dur = NEVER;
                    end else begin
                        o_blinks = blinks_dec;
                        o_alarm  = i_off_dur;
                    end
                end else if (fire) begin
                    o_lit     = 1'b1;
                    o_elapsed = '0;
                    o_alarm   = i_on_dur;
                end
            end
            OP_SET: begin
                o_lit     = i_word.turn_on;
                o_elapsed = '0;
                o_alarm   = NEVER;
                o_blinks  = BLINKS_ENDLESS;
                o_on_dur  = i_word.turn_on ? NEVER : '0;
                o_off_dur = i_word.turn_on ? '0 : NEVER;
            end
            OP_BLINK: begin
                o_lit     = 1'b0;
                o_elapsed = '0;
                if (i_word.blink_total == 32'd0) begin
                    o_alarm   = NEVER;
                    o_blinks  = BLINKS_ENDLESS;
                    o_on_dur  = '0;
                    o_off_dur = NEVER;
                end else begin
                    o_alarm   = to_time(i_word.start_delay);
                    o_blinks  = i_word.blink_total;
                    o_on_dur  = to_time(i_word.on_ticks);
                    o_off_dur = to_time(i_word.off_ticks);
                end
            end
            default: begin
            end
        endcase
        o_armed = (o_alarm != NEVER) && (o_blinks != 32'd0);
    end

endmodule

// ===== sv/mlbc_seq.sv =====
module mlbc_seq #(
    parameter int LED_COUNT = 3,
    parameter int IDX_W     = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_is_tick,
    input  logic                  i_out_busy,
    output mlbc_pkg::t_seq_ctrl   o_ctrl,
    output logic [IDX_W-1:0]      o_idx
);
    import mlbc_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              last;

    assign last  = (r_idx == IDX_W'(LED_COUNT - 1));
    assign o_idx = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    n_state = i_is_tick ? ST_TICK : ST_CMD;
                end
            end
            ST_TICK: begin
                if (last) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_CMD: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.accept = i_in_valid;
            end
            ST_TICK: begin
                o_ctrl.busy       = 1'b1;
                o_ctrl.tick_visit = 1'b1;
            end
            ST_CMD: begin
                o_ctrl.busy      = 1'b1;
                o_ctrl.cmd_visit = 1'b1;
            end
            ST_DONE: begin
                o_ctrl.busy     = 1'b1;
                o_ctrl.load_out = !i_out_busy;
            end
            default: begin
                o_ctrl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== sv/multi_led_blink_controller.sv =====
// Blink pattern generator for up to three LEDs.
// Input channel (i_in_valid / o_in_stall) takes one word: a tick, a steady
// set or a blink command for one LED. Every word yields one output word on
// o_out_valid / i_out_stall with the pin levels after polarity and the mask
// of LEDs that are blinking. Bits for LEDs at or above LED_COUNT read 0.
// One shared update unit (saturating increment, alarm compare, toggle)
// visits the LEDs in turn, one per cycle. A tick walks the sequencer through
// IDLE, TICK for each LED and DONE; a command through IDLE, CMD and DONE. The
// output word is registered in DONE, once the output register is free.
// o_in_stall is high while a word is in work. A finished word waits in the
// output register while the receiver stalls it; meanwhile the block may take
// and work one more input, then holds that result and stalls its input until
// the output register is free.
// The polarity register is written on i_cfg_valid / o_cfg_ready (always
// ready) and takes effect from the next word; write it only when idle.
// Synchronous active-low reset leaves every LED steadily dark, levels 7,
// and no output pending.
module multi_led_blink_controller #(
    parameter int LED_COUNT = 3,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mlbc_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mlbc_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_data
);
    import mlbc_pkg::*;

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [TIME_BITS-1:0] NEVER = {TIME_BITS{1'b1}};

    t_seq_ctrl             ctrl;
    logic [IDX_W-1:0]      visit_idx;
    logic [IDX_W-1:0]      addr;
    logic                  in_range;
    logic                  wr_en;
    t_unit_op              op;

    t_in_word              r_item;
    logic [2:0]            r_levels;
    logic [LED_COUNT-1:0]  r_lit;
    logic [LED_COUNT-1:0]  r_armed;
    logic [TIME_BITS-1:0]  r_elapsed [LED_COUNT];
    logic [TIME_BITS-1:0]  r_alarm   [LED_COUNT];
    logic [31:0]           r_blinks  [LED_COUNT];
    logic [TIME_BITS-1:0]  r_on_dur  [LED_COUNT];
    logic [TIME_BITS-1:0]  r_off_dur [LED_COUNT];

    logic                  n_lit;
    logic                  n_armed;
    logic [TIME_BITS-1:0]  n_elapsed;
    logic [TIME_BITS-1:0]  n_alarm;
    logic [31:0]           n_blinks;
    logic [TIME_BITS-1:0]  n_on_dur;
    logic [TIME_BITS-1:0]  n_off_dur;

    logic                  r_out_valid;
    t_out_word             r_out;
    t_out_word             n_out;

    mlbc_seq #(
        .LED_COUNT (LED_COUNT),
        .IDX_W     (IDX_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_tick  (i_in_word.func == FUNC_TICK),
        .i_out_busy (r_out_valid && i_out_stall),
        .o_ctrl     (ctrl),
        .o_idx      (visit_idx)
    );

    assign o_in_stall  = ctrl.busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        in_range = ({1'b0, r_item.led_index} < 4'(LED_COUNT));
        addr     = ctrl.tick_visit ? visit_idx : r_item.led_index[IDX_W-1:0];
        op       = OP_HOLD;
        if (ctrl.tick_visit) begin
            op = OP_TICK;
        end else if (ctrl.cmd_visit && in_range) begin
            unique case (r_item.func)
                FUNC_SET:   op = OP_SET;
                FUNC_BLINK: op = OP_BLINK;
                default:    op = OP_HOLD;
            endcase
        end
        wr_en = ctrl.tick_visit || (ctrl.cmd_visit && in_range);
    end

    mlbc_led_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_unit (
        .i_op      (op),
        .i_word    (r_item),
        .i_lit     (r_lit[addr]),
        .i_elapsed (r_elapsed[addr]),
        .i_alarm   (r_alarm[addr]),
        .i_blinks  (r_blinks[addr]),
        .i_on_dur  (r_on_dur[addr]),
        .i_off_dur (r_off_dur[addr]),
        .o_lit     (n_lit),
        .o_elapsed (n_elapsed),
        .o_alarm   (n_alarm),
        .o_blinks  (n_blinks),
        .o_on_dur  (n_on_dur),
        .o_off_dur (n_off_dur),
        .o_armed   (n_armed)
    );

    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_item <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (i_cfg_valid) begin
            r_levels <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit   <= '0;
            r_armed <= '0;
            for (int k = 0; k < LED_COUNT; k++) begin
                r_elapsed[k] <= '0;
                r_alarm[k]   <= NEVER;
                r_blinks[k]  <= BLINKS_ENDLESS;
                r_on_dur[k]  <= '0;
                r_off_dur[k] <= NEVER;
            end
        end else if (wr_en) begin
            r_lit[addr]     <= n_lit;
            r_armed[addr]   <= n_armed;
            r_elapsed[addr] <= n_elapsed;
            r_alarm[addr]   <= n_alarm;
            r_blinks[addr]  <= n_blinks;
            r_on_dur[addr]  <= n_on_dur;
            r_off_dur[addr] <= n_off_dur;
        end
    end

    always_comb begin
        n_out = '0;
        for (int k = 0; k < 3; k++) begin
            if (k < LED_COUNT) begin
                n_out.pin_levels[k]    = (r_lit[k] == r_levels[k]);
                n_out.blinking_mask[k] = r_armed[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== sv/mlbc_checker.sv =====
`include "multi_led_blink_controller_defines.svh"

module mlbc_port_checker #(
    parameter int LED_COUNT = 3
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input mlbc_pkg::t_out_word  o_out_word
);
    import mlbc_pkg::*;

    `MLBC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "output word dropped")
    `MLBC_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_word), "output changed")
    `MLBC_ASSERT(a_one_word, i_in_valid && !o_in_stall |=> o_in_stall, "second word taken")
    `MLBC_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `MLBC_ASSERT(a_unused_bits, o_out_valid |-> ((o_out_word.pin_levels | o_out_word.blinking_mask) >> LED_COUNT) == 3'd0, "bit set for absent LED")

endmodule

bind multi_led_blink_controller mlbc_port_checker #(
    .LED_COUNT (LED_COUNT)
) u_mlbc_port_checker (.*);

// ===== dv/mlbc_checker.sv =====
module mlbc_checker
    import mlbc_pkg::*;
#(
    parameter int LED_COUNT = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] NEVER = IN32_ALL_ONES;

    logic [2:0]  levels;
    logic        lit      [LED_COUNT];
    logic [31:0] elapsed  [LED_COUNT];
    logic [31:0] alarm    [LED_COUNT];
    logic [31:0] left     [LED_COUNT];
    logic [31:0] on_span  [LED_COUNT];
    logic [31:0] off_span [LED_COUNT];

    t_out_word   due_status [$];
    t_out_word   want;
    int          fails = 0;

    function automatic void set_steady(int k, logic on);
        lit[k]      = on;
        elapsed[k]  = '0;
        alarm[k]    = NEVER;
        left[k]     = BLINKS_ENDLESS;
        on_span[k]  = on ? NEVER : '0;
        off_span[k] = on ? '0 : NEVER;
    endfunction

    function automatic void tick_led(int k);
        if (elapsed[k] != NEVER) begin
            elapsed[k] = elapsed[k] + 1'b1;
        end
        if (alarm[k] == NEVER || elapsed[k] < alarm[k]) begin
            return;
        end
        if (lit[k]) begin
            lit[k] = 1'b0;
            if (left[k] != BLINKS_ENDLESS) begin
                left[k] = left[k] - 1'b1;
            end
            if (left[k] == '0) begin
                set_steady(k, 1'b0);
            end else begin
                elapsed[k] = '0;
                alarm[k]   = off_span[k];
            end
        end else begin
            lit[k]     = 1'b1;
            elapsed[k] = '0;
            alarm[k]   = on_span[k];
        end
    endfunction

    function automatic t_out_word next_led_status(t_in_word w);
        t_out_word s;
        case (w.func)
            FUNC_TICK: begin
                for (int k = 0; k < LED_COUNT; k++) begin
                    tick_led(k);
                end
            end
            FUNC_SET: begin
                if (w.led_index < LED_COUNT) begin
                    set_steady(w.led_index, w.turn_on);
                end
            end
            FUNC_BLINK: begin
                if (w.led_index < LED_COUNT) begin
                    if (w.blink_total == '0) begin
                        set_steady(w.led_index, 1'b0);
                    end else begin
                        lit[w.led_index]      = 1'b0;
                        left[w.led_index]     = w.blink_total;
                        on_span[w.led_index]  = w.on_ticks;
                        off_span[w.led_index] = w.off_ticks;
                        elapsed[w.led_index]  = '0;
                        alarm[w.led_index]    = w.start_delay;
                    end
                end
            end
            default: ;
        endcase
        s = '0;
        for (int k = 0; k < LED_COUNT; k++) begin
            s.pin_levels[k]    = (lit[k] == levels[k]);
            s.blinking_mask[k] = (alarm[k] != NEVER) && (left[k] != '0);
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            levels = LEVELS_RESET;
            for (int k = 0; k < LED_COUNT; k++) begin
                set_steady(k, 1'b0);
            end
            due_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                levels = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                due_status.push_back(next_led_status(i_in_word));
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_status.size() == 0) begin
                    $error("output word %h with none expected", i_out_word);
                    fails++;
                end else begin
                    want = due_status.pop_front();
                    if (i_out_word.pin_levels !== want.pin_levels) begin
                        $error("pin_levels: expected %b, actual %b",
                               want.pin_levels, i_out_word.pin_levels);
                        fails++;
                    end
                    if (i_out_word.blinking_mask !== want.blinking_mask) begin
                        $error("blinking_mask: expected %b, actual %b",
                               want.blinking_mask, i_out_word.blinking_mask);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= due_status.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mlbc_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [31:0] ALL_ONES  = IN32_ALL_ONES;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_word   in_word;
    logic       out_valid;
    logic       out_stall;
    t_out_word  out_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;
    int         fail_count;
    int         pending;
    bit         no_idle = 1'b0;

    multi_led_blink_controller #(
        .LED_COUNT (3),
        .TIME_BITS (32)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    mlbc_checker #(
        .LED_COUNT (3)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400us;
        $display("Verification failed");
        $finish;
    end

    function automatic t_in_word cmd(logic [1:0] f, logic [2:0] idx, logic on,
                                     logic [31:0] total, logic [31:0] on_t,
                                     logic [31:0] off_t, logic [31:0] delay);
        t_in_word w;
        w.func        = f;
        w.led_index   = idx;
        w.turn_on     = on;
        w.blink_total = total;
        w.on_ticks    = on_t;
        w.off_ticks   = off_t;
        w.start_delay = delay;
        return w;
    endfunction

    function automatic logic [31:0] pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) begin
            return $urandom_range(0, 6);
        end
        if (r == 8) begin
            return $urandom;
        end
        return ALL_ONES;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int r;
        int t;
        r = $urandom_range(0, 99);
        w = cmd(FUNC_TICK, 3'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                $urandom, $urandom, $urandom, $urandom);
        if (r < 55) begin
            w.func = FUNC_TICK;
        end else if (r < 75) begin
            w.func = FUNC_BLINK;
            t = $urandom_range(0, 19);
            if (t < 14) begin
                w.blink_total = $urandom_range(1, 4);
            end else if (t < 17) begin
                w.blink_total = BLINKS_ENDLESS;
            end else if (t < 18) begin
                w.blink_total = '0;
            end
            w.on_ticks    = pick_span();
            w.off_ticks   = pick_span();
            w.start_delay = pick_span();
        end else if (r < 90) begin
            w.func = FUNC_SET;
        end else if (r < 96) begin
            w.func      = $urandom_range(0, 1) ? FUNC_SET : FUNC_BLINK;
            w.led_index = 3'($urandom_range(3, 7));
        end else begin
            w.func = FUNC_SPARE;
        end
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_levels(logic [2:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int stall_cycles;
        int taken;
        taken = 0;
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            // hold off once for long enough to back the block up
            if (taken == 120) begin
                stall_cycles = 80;
            end else begin
                stall_cycles = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin : stimulus
        logic [2:0] phase_levels;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_levels(3'd5);
        send_word(cmd(FUNC_TICK, 3'd0, 1'b0, '0, '0, '0, '0));
        send_word(cmd(FUNC_SET, 3'd0, 1'b1, '0, '0, '0, '0));
        send_word(cmd(FUNC_SET, 3'd1, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_word(cmd(FUNC_SET, 3'd2, 1'b0, '0, '0, '0, '0));
        send_word(cmd(FUNC_SET, 3'd7, 1'b1, '0, '0, '0, '0));
        send_word(cmd(FUNC_BLINK, 3'd5, 1'b1, 32'd2, 32'd1, 32'd1, '0));
        send_word(cmd(FUNC_SPARE, 3'd7, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_word(cmd(FUNC_BLINK, 3'd0, 1'b1, '0, 32'd3, 32'd3, 32'd1));
        send_word(cmd(FUNC_BLINK, 3'd1, 1'b0, 32'd2, 32'd1, '0, '0));
        send_word(cmd(FUNC_BLINK, 3'd2, 1'b0, ALL_ONES, '0, 32'd1, 32'd1));
        send_word(cmd(FUNC_BLINK, 3'd0, 1'b0, 32'd1, ALL_ONES, '0, 32'd2));
        repeat (8) send_word(cmd(FUNC_TICK, 3'd0, 1'b0, '0, '0, '0, '0));
        send_word(cmd(FUNC_BLINK, 3'd1, 1'b0, 32'd3, 32'hFFFF_FFFE, ALL_ONES, ALL_ONES));
        send_word(cmd(FUNC_TICK, 3'd7, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_word(cmd(FUNC_BLINK, 3'd2, 1'b0, 32'd1, '0, '0, '0));
        send_word(cmd(FUNC_TICK, 3'd0, 1'b0, '0, '0, '0, '0));
        send_word(cmd(FUNC_TICK, 3'd0, 1'b0, '0, '0, '0, '0));
        send_word(cmd(FUNC_SET, 3'd1, 1'b0, 32'd9, 32'd9, 32'd9, 32'd9));

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       phase_levels = 3'd0;
                1:       phase_levels = 3'd7;
                3:       phase_levels = 3'd2;
                default: phase_levels = 3'($urandom_range(0, 7));
            endcase
            write_levels(phase_levels);
            no_idle = (p == 2);
            repeat (130) send_word(random_word());
        end
        no_idle = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== multi_led_blink_controller.f =====
+incdir+sv
sv/mlbc_pkg.sv
sv/mlbc_led_unit.sv
sv/mlbc_seq.sv
sv/multi_led_blink_controller.sv
sv/mlbc_checker.sv
dv/mlbc_checker.sv
dv/tb.sv
